@@ sv/t2ws_pkg.sv @@
// ----------------------------------------------------------------------------
// t2ws_pkg
// Shared types, register map and the tangent table for the twist converter.
// ----------------------------------------------------------------------------
package t2ws_pkg;

  localparam int SPEED_BITS_DEF = 16;
  localparam int NSTG           = 15;
  localparam int ADDR_BITS      = 4;

  localparam logic [ADDR_BITS-1:0] ADDR_MODE   = 4'd0;
  localparam logic [ADDR_BITS-1:0] ADDR_OFFSET = 4'd4;
  localparam logic [ADDR_BITS-1:0] ADDR_WBASE  = 4'd8;

  localparam logic [9:0]  RST_OFFSET = 10'd32;
  localparam logic [11:0] RST_WBASE  = 12'd243;

  typedef struct packed {
    logic        diff;
    logic [9:0]  offset;
    logic [11:0] wheelbase;
  } cfg_t;

  typedef logic [63:0] tan_tab_t [90];

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
  localparam logic [63:0] STEP_Q60 = PI_Q60 / 64'd180;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[123:60];
  endfunction

  // shift-subtract long division, quotient and remainder
  function automatic logic [127:0] udivmod(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return {q, r[63:0]};
  endfunction

  function automatic tan_tab_t build_tan();
    tan_tab_t    tab;
    logic [63:0] x, s, c, t, q, r, n;
    logic [127:0] qr;
    logic        neg;
    for (int k = 0; k < 90; k++) tab[k] = '0;
    for (int k = 1; k < 90; k++) begin
      x = STEP_Q60 * 64'(k);
      s = x;
      c = ONE_Q60;
      t = x;
      neg = 1'b1;
      n = 64'd1;
      for (int it = 0; it < 48; it++) begin
        if (t != 0) begin
          qr = udivmod(mul_q60(t, x), n + 64'd1);
          t = qr[127:64];
          qr = udivmod(mul_q60(t, x), n + 64'd2);
          t = qr[127:64];
          s = neg ? s - t : s + t;
          neg = !neg;
          n = n + 64'd2;
        end
      end
      t = ONE_Q60;
      neg = 1'b1;
      n = 64'd0;
      for (int it = 0; it < 48; it++) begin
        if (t != 0) begin
          qr = udivmod(mul_q60(t, x), n + 64'd1);
          t = qr[127:64];
          qr = udivmod(mul_q60(t, x), n + 64'd2);
          t = qr[127:64];
          c = neg ? c - t : c + t;
          neg = !neg;
          n = n + 64'd2;
        end
      end
      qr = udivmod(s, c);
      q = qr[127:64];
      r = qr[63:0];
      for (int i = 0; i < 32; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= c) begin
          r = r - c;
          q[0] = 1'b1;
        end
      end
      tab[k] = q;
    end
    tab[45] = 64'h0000000100000000;
    return tab;
  endfunction

  localparam tan_tab_t TAN_Q32 = build_tan();

endpackage

@@ sv/twist_to_wheel_and_steer.sv @@
// ----------------------------------------------------------------------------
// twist_to_wheel_and_steer
// Velocity command to rear wheel speeds and front steering angle.
// pipeline: 15 register stages, the result is registered in the last stage
// throughput: one request per cycle, unless a held output (out_stall) backs the pipeline up;
// stalled stages hold, empty stages fill, so bubbles close up
// reset: synchronous, clears pipeline valid bits and loads register defaults
// ----------------------------------------------------------------------------
module twist_to_wheel_and_steer #(
  parameter int SPEED_BITS = t2ws_pkg::SPEED_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [t2ws_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             linear_speed,
  input  logic signed [15:0]             yaw_rate,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SPEED_BITS-1:0]   left_wheel_speed,
  output logic signed [SPEED_BITS-1:0]   right_wheel_speed,
  output logic signed [7:0]              steer_angle_deg,
  output logic                           speed_clipped
);
  import t2ws_pkg::*;

  cfg_t            cfg;
  logic [NSTG:1]   vld;
  logic [NSTG:1]   rdy;

  t2ws_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  t2ws_wheel #(.SPEED_BITS(SPEED_BITS)) u_wheel (
    .clk, .en(rdy), .cfg, .linear_speed, .yaw_rate,
    .left_wheel_speed, .right_wheel_speed, .speed_clipped
  );

  t2ws_angle u_angle (
    .clk, .en(rdy), .cfg, .linear_speed, .yaw_rate, .steer_angle_deg
  );

  always_comb begin
    rdy[NSTG] = !vld[NSTG] || !out_stall;
    for (int i = NSTG - 1; i >= 1; i--) rdy[i] = !vld[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= in_valid;
      for (int i = 2; i <= NSTG; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld[NSTG];

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (rst) in_stall |-> vld[NSTG])
    else $error("input stalled while output stage empty");
  a_empty_go: assert property (@(posedge clk) disable iff (rst) !vld[NSTG] |-> !in_stall)
    else $error("input stalled with free output stage");
  a_angle_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (steer_angle_deg <= 8'sd89 && steer_angle_deg >= -8'sd89))
    else $error("steering angle out of range");
`endif

endmodule

@@ sv/t2ws_regs.sv @@
// ----------------------------------------------------------------------------
// t2ws_regs
// Configuration register file behind a simple bus port.
// ----------------------------------------------------------------------------
module t2ws_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [t2ws_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output t2ws_pkg::cfg_t                   cfg
);
  import t2ws_pkg::*;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff      <= 1'b0;
      cfg.offset    <= RST_OFFSET;
      cfg.wheelbase <= RST_WBASE;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_MODE:   cfg.diff      <= pwdata[0];
        ADDR_OFFSET: cfg.offset    <= pwdata[9:0];
        ADDR_WBASE:  cfg.wheelbase <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_MODE:   prdata = {31'b0, cfg.diff};
      ADDR_OFFSET: prdata = {22'b0, cfg.offset};
      ADDR_WBASE:  prdata = {20'b0, cfg.wheelbase};
      default:     prdata = '0;
    endcase
  end

endmodule

@@ sv/t2ws_wheel.sv @@
// ----------------------------------------------------------------------------
// t2ws_wheel
// Wheel speed path: offset product, divide by 1000, saturate and clamp.
// ----------------------------------------------------------------------------
module t2ws_wheel #(
  parameter int SPEED_BITS = t2ws_pkg::SPEED_BITS_DEF
) (
  input  logic                         clk,
  input  logic [t2ws_pkg::NSTG:1]      en,
  input  t2ws_pkg::cfg_t               cfg,
  input  logic signed [15:0]           linear_speed,
  input  logic signed [15:0]           yaw_rate,
  output logic signed [SPEED_BITS-1:0] left_wheel_speed,
  output logic signed [SPEED_BITS-1:0] right_wheel_speed,
  output logic                         speed_clipped
);
  import t2ws_pkg::*;

  localparam logic [20:0] RECIP = 21'd1073741;
  localparam logic signed [33:0] HI = (34'sd1 <<< (SPEED_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] LO = -HI - 34'sd1;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] left;
    logic signed [SPEED_BITS-1:0] right;
    logic                         clip;
  } whl_t;

  logic signed [15:0] v1, w1;
  logic signed [27:0] nl2, nr2, vk, wo;
  logic               vz2, vn2, vz3, vn3, vz4, vn4, vz5, vn5, vz6, vn6;
  logic [25:0]        ml3, mr3, ml4, mr4;
  logic               sl3, sr3, sl4, sr4, sl5, sr5;
  logic [16:0]        ql4, qr4, ql5, qr5;
  logic [10:0]        rl5, rr5;
  logic [46:0]        pl, pr;
  logic [25:0]        dl, dr;
  logic signed [33:0] xl, xr;
  logic signed [SPEED_BITS-1:0] l6, r6, cl, cr;
  logic               cll6, clr6;
  whl_t               dly [7:NSTG];

  function automatic logic signed [33:0] wval(input logic [16:0] q, input logic [10:0] r,
                                              input logic sg);
    logic [16:0] qc;
    qc = q + {16'b0, (r >= 11'd1000)};
    return sg ? -$signed(34'(qc)) : $signed(34'(qc));
  endfunction

  assign vk = 28'(v1) * 28'sd1000;
  assign wo = 28'(w1) * $signed(28'(cfg.offset));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      v1 <= linear_speed;
      w1 <= yaw_rate;
    end
    if (en[2]) begin
      nl2 <= vk - wo;
      nr2 <= vk + wo;
      vz2 <= (v1 == 16'sd0);
      vn2 <= v1[15];
    end
    if (en[3]) begin
      ml3 <= nl2[27] ? 26'(-nl2) : nl2[25:0];
      mr3 <= nr2[27] ? 26'(-nr2) : nr2[25:0];
      sl3 <= nl2[27];
      sr3 <= nr2[27];
      vz3 <= vz2;
      vn3 <= vn2;
    end
    if (en[4]) begin
      ql4 <= pl[46:30];
      qr4 <= pr[46:30];
      ml4 <= ml3;
      mr4 <= mr3;
      sl4 <= sl3;
      sr4 <= sr3;
      vz4 <= vz3;
      vn4 <= vn3;
    end
    if (en[5]) begin
      rl5 <= dl[10:0];
      rr5 <= dr[10:0];
      ql5 <= ql4;
      qr5 <= qr4;
      sl5 <= sl4;
      sr5 <= sr4;
      vz5 <= vz4;
      vn5 <= vn4;
    end
    if (en[6]) begin
      l6   <= (xl > HI) ? HI[SPEED_BITS-1:0] : (xl < LO) ? LO[SPEED_BITS-1:0] :
              xl[SPEED_BITS-1:0];
      r6   <= (xr > HI) ? HI[SPEED_BITS-1:0] : (xr < LO) ? LO[SPEED_BITS-1:0] :
              xr[SPEED_BITS-1:0];
      cll6 <= (xl > HI) || (xl < LO);
      clr6 <= (xr > HI) || (xr < LO);
      vz6  <= vz5;
      vn6  <= vn5;
    end
    if (en[7]) begin
      dly[7] <= '{left: cl, right: cr, clip: (cll6 || clr6) && !(vz6 && !cfg.diff)};
    end
  end

  assign pl = 47'(ml3) * 47'(RECIP);
  assign pr = 47'(mr3) * 47'(RECIP);
  assign dl = ml4 - 26'(ql4) * 26'd1000;
  assign dr = mr4 - 26'(qr4) * 26'd1000;
  assign xl = wval(ql5, rl5, sl5);
  assign xr = wval(qr5, rr5, sr5);

  // ackermann: stop gives zero, otherwise wheels may not oppose the motion
  always_comb begin
    cl = l6;
    cr = r6;
    if (!cfg.diff) begin
      if (vz6) begin
        cl = '0;
        cr = '0;
      end else if (vn6) begin
        if (!l6[SPEED_BITS-1] && l6 != '0) cl = '0;
        if (!r6[SPEED_BITS-1] && r6 != '0) cr = '0;
      end else begin
        if (l6[SPEED_BITS-1]) cl = '0;
        if (r6[SPEED_BITS-1]) cr = '0;
      end
    end
  end

  for (genvar i = 8; i <= NSTG; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[i]) dly[i] <= dly[i-1];
    end
  end

  assign left_wheel_speed  = dly[NSTG].left;
  assign right_wheel_speed = dly[NSTG].right;
  assign speed_clipped     = dly[NSTG].clip;

endmodule

@@ sv/t2ws_angle.sv @@
// ----------------------------------------------------------------------------
// t2ws_angle
// Steering angle path: pipelined ratio divider and tangent table search.
// ----------------------------------------------------------------------------
module t2ws_angle (
  input  logic                    clk,
  input  logic [t2ws_pkg::NSTG:1] en,
  input  t2ws_pkg::cfg_t          cfg,
  input  logic signed [15:0]      linear_speed,
  input  logic signed [15:0]      yaw_rate,
  output logic signed [7:0]       steer_angle_deg
);
  import t2ws_pkg::*;

  localparam int NDIV = 10;

  logic [15:0] av1, aw1;
  logic        ng1, lv1, ng2, lv2;
  logic [27:0] a2;
  logic [24:0] b2;
  logic [24:0] rs [0:NDIV];
  logic [39:0] qs [0:NDIV];
  logic [24:0] ds [0:NDIV];
  logic [7:0]  lo [0:NDIV];
  logic        bg [0:NDIV];
  logic        ng [0:NDIV];
  logic        lv [0:NDIV];
  logic [89:1] ge, ge14;
  logic        ng14;
  logic [6:0]  cnt;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      av1 <= linear_speed[15] ? 16'(-linear_speed) : linear_speed;
      aw1 <= yaw_rate[15] ? 16'(-yaw_rate) : yaw_rate;
      ng1 <= linear_speed[15] ^ yaw_rate[15];
      lv1 <= !cfg.diff && (linear_speed != 16'sd0) && (yaw_rate != 16'sd0);
    end
    if (en[2]) begin
      a2  <= 28'(cfg.wheelbase) * 28'(aw1);
      b2  <= 25'(av1) * 25'd1000;
      ng2 <= ng1;
      lv2 <= lv1;
    end
    if (en[3]) begin
      bg[0] <= {5'b0, a2} >= {b2, 8'b0};
      rs[0] <= {5'b0, a2[27:8]};
      lo[0] <= a2[7:0];
      ds[0] <= b2;
      qs[0] <= '0;
      ng[0] <= ng2;
      lv[0] <= lv2;
    end
  end

  // four quotient bits per stage
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [39:0] nn;
    logic [25:0] rt;
    logic [24:0] rn;
    logic [39:0] qn;
    assign nn = {lo[j], 32'b0};
    always_comb begin
      rn = rs[j];
      qn = qs[j];
      for (int b = 0; b < 4; b++) begin
        rt = {rn, nn[39 - 4*j - b]};
        qn = {qn[38:0], 1'b0};
        if (rt >= {1'b0, ds[j]}) begin
          rt = rt - {1'b0, ds[j]};
          qn[0] = 1'b1;
        end
        rn = rt[24:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en[4+j]) begin
        rs[j+1] <= rn;
        qs[j+1] <= qn;
        ds[j+1] <= ds[j];
        lo[j+1] <= lo[j];
        bg[j+1] <= bg[j];
        ng[j+1] <= ng[j];
        lv[j+1] <= lv[j];
      end
    end
  end

  always_comb begin
    for (int k = 1; k < 90; k++) begin
      ge[k] = lv[NDIV] && (bg[NDIV] || (qs[NDIV] >= TAN_Q32[k][39:0]));
    end
  end

  assign cnt = 7'($countones(ge14));

  always_ff @(posedge clk) begin
    if (en[14]) begin
      ge14 <= ge;
      ng14 <= ng[NDIV];
    end
    if (en[15]) begin
      steer_angle_deg <= ng14 ? $signed(8'd0 - {1'b0, cnt}) : $signed({1'b0, cnt});
    end
  end

endmodule

@@ test/twist_checker.sv @@
// ----------------------------------------------------------------------------
// twist_checker
// Watches the command and result channels of the twist converter, predicts
// wheel speeds, steering angle and clip flag for every accepted request, and
// compares each accepted result against the oldest prediction in order.
// ----------------------------------------------------------------------------
module twist_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               diff_mode,
  input  logic [9:0]         offset_mm,
  input  logic [11:0]        wbase_mm,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] linear_speed,
  input  logic signed [15:0] yaw_rate,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] left_wheel_speed,
  input  logic signed [15:0] right_wheel_speed,
  input  logic signed [7:0]  steer_angle_deg,
  input  logic               speed_clipped,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [7:0]  angle;
    logic               clip;
  } wheel_cmd_t;

  wheel_cmd_t expected_cmds[$];
  logic [63:0] tan_q32 [90];

  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[123:60];
  endfunction

  initial begin
    logic [63:0] x, s, c, t, q, r, n, step;
    logic neg;
    step = 64'h3243F6A8885A308D / 64'd180;
    tan_q32[0] = 0;
    for (int k = 1; k < 90; k++) begin
      x = step * 64'(k);
      s = x; c = 64'h1000000000000000; t = x; neg = 1; n = 1;
      while (t != 0) begin
        t = q60_mul(t, x) / (n + 1);
        t = q60_mul(t, x) / (n + 2);
        s = neg ? s - t : s + t;
        neg = !neg; n = n + 2;
      end
      t = 64'h1000000000000000; neg = 1; n = 0;
      while (t != 0) begin
        t = q60_mul(t, x) / (n + 1);
        t = q60_mul(t, x) / (n + 2);
        c = neg ? c - t : c + t;
        neg = !neg; n = n + 2;
      end
      q = s / c; r = s % c;
      for (int i = 0; i < 32; i++) begin
        r = r << 1; q = q << 1;
        if (r >= c) begin
          r = r - c; q[0] = 1;
        end
      end
      tan_q32[k] = q;
    end
    tan_q32[45] = 64'h100000000;
  end

  function automatic longint clamp16(longint w, inout logic clip);
    if (w > 32767) begin
      clip = 1; return 32767;
    end
    if (w < -32768) begin
      clip = 1; return -32768;
    end
    return w;
  endfunction

  function automatic wheel_cmd_t predict_wheels(longint v, longint w);
    wheel_cmd_t res;
    longint l, rr, d, off;
    logic clip;
    logic [127:0] a, b;
    clip = 0; l = 0; rr = 0; d = 0; off = offset_mm;
    if (diff_mode) begin
      l = clamp16((1000 * v - w * off) / 1000, clip);
      rr = clamp16((1000 * v + w * off) / 1000, clip);
    end else if (v == 0) begin
    end else if (w == 0) begin
      l = clamp16(v, clip); rr = l;
    end else begin
      l = clamp16((1000 * v - w * off) / 1000, clip);
      rr = clamp16((1000 * v + w * off) / 1000, clip);
      if (v > 0) begin
        if (l < 0) l = 0;
        if (rr < 0) rr = 0;
      end else begin
        if (l > 0) l = 0;
        if (rr > 0) rr = 0;
      end
      a = 128'(wbase_mm) * 128'(w < 0 ? -w : w);
      b = 128'(1000) * 128'(v < 0 ? -v : v);
      for (int k = 1; k < 90; k++)
        if ((a << 32) >= 128'(tan_q32[k]) * b) d++;
      if ((v < 0) != (w < 0)) d = -d;
    end
    res.left = l[15:0]; res.right = rr[15:0]; res.angle = d[7:0]; res.clip = clip;
    return res;
  endfunction

  always @(posedge clk) begin
    wheel_cmd_t e;
    if (rst) begin
      expected_cmds.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t unexpected result %0d %0d %0d %0d", $time, left_wheel_speed,
                   right_wheel_speed, steer_angle_deg, speed_clipped);
          errors <= errors + 1;
        end else begin
          e = expected_cmds.pop_front();
          if (e != {left_wheel_speed, right_wheel_speed, steer_angle_deg, speed_clipped})
          begin
            $display("%0t expected %0d %0d %0d %0d actual %0d %0d %0d %0d", $time,
                     e.left, e.right, e.angle, e.clip, left_wheel_speed,
                     right_wheel_speed, steer_angle_deg, speed_clipped);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_cmds.push_back(predict_wheels(linear_speed, yaw_rate));
      pending <= expected_cmds.size();
    end
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives velocity commands and register settings into the twist converter,
// with random idling on both channels, a long output hold-off and a drain
// pause; the checker beside the block supplies the verdict.
// ----------------------------------------------------------------------------
module tb;
  import t2ws_pkg::*;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [15:0] linear_speed = 0, yaw_rate = 0;
  logic signed [15:0] left_wheel_speed, right_wheel_speed;
  logic signed [7:0] steer_angle_deg;
  logic speed_clipped;
  logic diff_mode = 0;
  logic [9:0] offset_mm = RST_OFFSET;
  logic [11:0] wbase_mm = RST_WBASE;
  int errors, pending, cycles = 0;
  bit quiet = 0, hold_long = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  twist_to_wheel_and_steer dut (.*);

  twist_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("twist_to_wheel_and_steer: mismatch");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (60) @(posedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic reg_write(logic [ADDR_BITS-1:0] a, logic [31:0] d);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (a == ADDR_MODE) diff_mode <= d[0];
    else if (a == ADDR_OFFSET) offset_mm <= d[9:0];
    else wbase_mm <= d[11:0];
  endtask

  task automatic send_cmd(logic [15:0] v, logic [15:0] w);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1; linear_speed <= v; yaw_rate <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_field();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 200)) - 16'd100;
      1: return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] dv[8];
    dv = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd1000, -16'sd1000, 16'd5};
    repeat (7) @(posedge clk);
    rst <= 0;
    for (int m = 0; m < 2; m++) begin
      reg_write(ADDR_MODE, m);
      for (int i = 0; i < 8; i += 2)
        for (int j = 0; j < 8; j += 3) send_cmd(dv[i], dv[(j + i) % 8]);
      drain();
    end
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(ADDR_MODE, ph % 2);
      reg_write(ADDR_OFFSET, ph == 0 ? 0 : ph == 1 ? 1023 : $urandom_range(0, 1023));
      reg_write(ADDR_WBASE, ph == 2 ? 1 : ph == 3 ? 4095 : $urandom_range(1, 4095));
      if (ph == 5) quiet = 1;
      if (ph == 2) hold_long = 1;
      for (int i = 0; i < 150; i++) send_cmd(rnd_field(), rnd_field());
      drain();
    end
    if (errors == 0) begin
      $display("twist_to_wheel_and_steer: match");
    end else begin
      $display("twist_to_wheel_and_steer: mismatch");
    end
    $finish;
  end

endmodule
